// ===== hdl/explicit_free_list_allocator_defines.svh =====
// Assertion macros for the allocator.
`ifndef EXPLICIT_FREE_LIST_ALLOCATOR_DEFINES_SVH
`define EXPLICIT_FREE_LIST_ALLOCATOR_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Clocked check, held off while reset is low.
`define EFLA_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Clocked check that also holds through reset.
`define EFLA_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define EFLA_ASSERT(lbl, clk, rst_n, prop, msg)
`define EFLA_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

// ===== hdl/efla_pkg.sv =====
package efla_pkg;

    localparam int HEAP_BYTES_DEF      = 65536;
    localparam int MIN_SPLIT_BYTES_DEF = 24;

    localparam int WORD_W  = 32;
    localparam int COUNT_W = 13;
    localparam int CHUNK_W = 17;
    localparam int SIZE_W  = 16;
    localparam int ADDR_W  = 16;
    localparam int STAT_W  = 2;

    localparam logic [CHUNK_W-1:0] CHUNK_RESET = 17'd4096;

    typedef logic [WORD_W-1:0]  t_word;
    typedef logic [COUNT_W-1:0] t_count;

    typedef enum logic [STAT_W-1:0] {
        ST_OK   = 2'd0,
        ST_NULL = 2'd1,
        ST_OOM  = 2'd2
    } t_status;

    typedef enum logic {
        CMD_ALLOC = 1'b0,
        CMD_FREE  = 1'b1
    } t_cmd;

    localparam t_word SMALLEST_BLOCK = 32'd16;
    localparam t_word PROLOGUE_TAG   = 32'h9;
    localparam t_word EPILOGUE_TAG   = 32'h1;
    localparam t_word SIZE_MASK      = ~32'h7;

    // One access to the heap word memory; addr is a byte offset.
    typedef struct packed {
        logic  en;
        logic  we;
        t_word addr;
        t_word wdata;
    } t_mem_req;

endpackage

// ===== hdl/efla_if.sv =====
interface efla_cmd_if;
    logic        valid;
    logic        ready;
    logic        command;
    logic [15:0] size_bytes;
    logic [15:0] block_addr;
    modport source (output valid, output command, output size_bytes, output block_addr,
                    input ready);
    modport sink   (input valid, input command, input size_bytes, input block_addr,
                    output ready);
endinterface

interface efla_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [15:0] result_addr;
    logic [12:0] free_blocks;
    modport source (output valid, output status, output result_addr, output free_blocks,
                    input ready);
    modport sink   (input valid, input status, input result_addr, input free_blocks,
                    output ready);
endinterface

interface efla_cfg_if;
    logic        valid;
    logic        ready;
    logic [16:0] chunk_bytes;
    modport source (output valid, output chunk_bytes, input ready);
    modport sink   (input valid, input chunk_bytes, output ready);
endinterface

// ===== hdl/efla_mem.sv =====
module efla_mem #(
    parameter int HEAP_BYTES = efla_pkg::HEAP_BYTES_DEF
) (
    input  logic              i_clk,
    input  efla_pkg::t_mem_req i_req,
    output efla_pkg::t_word   o_rdata
);
    import efla_pkg::*;

    localparam int WORDS = HEAP_BYTES / 4;
    localparam int AW    = $clog2(WORDS);

    t_word r_mem [WORDS];
    logic [AW-1:0] w_idx;

    assign w_idx = i_req.addr[AW+1:2];

    always_ff @(posedge i_clk) begin
        if (i_req.en) begin
            if (i_req.we) begin
                r_mem[w_idx] <= i_req.wdata;
            end else begin
                o_rdata <= r_mem[w_idx];
            end
        end
    end

endmodule

// ===== hdl/efla_ctrl.sv =====
module efla_ctrl #(
    parameter int HEAP_BYTES      = efla_pkg::HEAP_BYTES_DEF,
    parameter int MIN_SPLIT_BYTES = efla_pkg::MIN_SPLIT_BYTES_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    efla_cmd_if.sink           i_cmd,
    efla_rsp_if.source         o_rsp,
    efla_cfg_if.sink           i_cfg,
    output efla_pkg::t_mem_req o_req,
    input  efla_pkg::t_word    i_rdata
);
    import efla_pkg::*;

    localparam int OW = $clog2(HEAP_BYTES + 1);

    typedef enum logic [5:0] {
        S_IDLE, S_LAY, S_ASTART, S_SRCH, S_SRCH_T, S_SRCH_N, S_NOFIT, S_AGROWN,
        S_GROW, S_GROW_W,
        S_M0, S_M1, S_M2, S_M3, S_M4, S_M5, S_M6, S_M7,
        S_PUSH0, S_PUSH1, S_PUSH2,
        S_U0, S_U1, S_U2, S_U3, S_U4,
        S_C0, S_C1, S_C2, S_C3, S_CW, S_C4, S_C5, S_CN0, S_CN1,
        S_F0, S_F1, S_FW, S_DONE
    } t_state;

    t_state r_state, r_ret_grow, r_ret_merge, r_ret_unl;

    logic          r_ready_heap;
    logic [OW-1:0] r_brk;
    t_word         r_head;
    t_count        r_count;
    logic [16:0]   r_chunk;

    logic [15:0]   r_size, r_addr;
    t_word         r_asize, r_gbytes, r_gn;
    logic          r_gfail;
    t_word         r_b, r_s, r_pr, r_nx, r_u, r_un, r_up, r_c, r_rs, r_n, r_p, r_r;
    logic          r_prev_used;
    t_count        r_left;
    logic [2:0]    r_cnt;
    t_status       r_status;
    logic [15:0]   r_result;

    logic          r_ov;
    t_status       r_o_status;
    logic [15:0]   r_o_result;
    t_count        r_o_free;

    t_word w_tsz, w_rem, w_gw, w_gn;
    logic  w_fit, w_split, w_gfail, w_fbad, w_fbad2, w_emit;

    assign i_cmd.ready   = (r_state == S_IDLE);
    assign i_cfg.ready   = 1'b1;
    assign o_rsp.valid   = r_ov;
    assign o_rsp.status  = r_o_status;
    assign o_rsp.result_addr = r_o_result;
    assign o_rsp.free_blocks = r_o_free;

    // load the output register once the previous result has gone
    assign w_emit  = (r_state == S_DONE) && (!r_ov || o_rsp.ready);

    assign w_tsz   = i_rdata & SIZE_MASK;
    assign w_fit   = !i_rdata[0] && (w_tsz >= r_asize);
    assign w_rem   = w_tsz - r_asize;
    assign w_split = (w_tsz >= r_asize) && (w_rem >= t_word'(MIN_SPLIT_BYTES));
    // round to an even word count, smallest block 16 bytes
    assign w_gw    = {2'b00, r_gbytes[31:2]};
    assign w_gn    = ((w_gw + {31'd0, w_gw[0]}) << 2) < SMALLEST_BLOCK ? SMALLEST_BLOCK
                   : ((w_gw + {31'd0, w_gw[0]}) << 2);
    assign w_gfail = (33'(r_brk) + 33'(w_gn)) > 33'(HEAP_BYTES);
    assign w_fbad  = (r_addr[2:0] != 3'd0) || (r_addr < 16'd16)
                   || (t_word'(r_addr) >= t_word'(r_brk));
    assign w_fbad2 = !i_rdata[0] || (w_tsz < SMALLEST_BLOCK)
                   || ((33'(r_addr) + 33'(w_tsz) - 33'd4) > 33'(r_brk));

    // Memory access issued by each state
    always_comb begin
        o_req = '0;
        unique case (r_state)
            S_LAY: begin
                o_req = '{en: 1'b1, we: 1'b1, addr: t_word'({r_cnt[1:0], 2'b00}),
                          wdata: '0};
                case (r_cnt[1:0])
                    2'd1, 2'd2: o_req.wdata = PROLOGUE_TAG;
                    2'd3:       o_req.wdata = EPILOGUE_TAG;
                    default:    o_req.wdata = '0;
                endcase
            end
            S_SRCH: begin
                o_req.en   = (r_b != '0) && (r_left != '0);
                o_req.addr = r_b - 32'd4;
            end
            S_SRCH_T: begin
                o_req.en   = !w_fit;
                o_req.addr = r_b;
            end
            S_GROW_W: begin
                o_req.en = 1'b1;
                o_req.we = 1'b1;
                case (r_cnt)
                    3'd0: o_req.addr = r_b - 32'd4;
                    3'd1: o_req.addr = r_b + r_gn - 32'd8;
                    3'd2: o_req.addr = r_b + r_gn - 32'd4;
                    3'd3: o_req.addr = r_b;
                    default: o_req.addr = r_b + 32'd4;
                endcase
                case (r_cnt)
                    3'd0, 3'd1: o_req.wdata = r_gn;
                    3'd2:       o_req.wdata = EPILOGUE_TAG;
                    default:    o_req.wdata = '0;
                endcase
            end
            S_M0: begin
                o_req.en = 1'b1; o_req.addr = r_b - 32'd4;
            end
            S_M1: begin
                o_req.en = 1'b1; o_req.addr = r_b - 32'd8;
            end
            S_M2: begin
                o_req.en = 1'b1; o_req.addr = r_b + r_s - 32'd4;
            end
            S_M4: begin
                o_req.en = !r_prev_used; o_req.addr = r_pr - 32'd4;
            end
            S_M6: begin
                o_req = '{en: 1'b1, we: 1'b1, addr: r_b - 32'd4, wdata: r_s};
            end
            S_M7: begin
                o_req = '{en: 1'b1, we: 1'b1, addr: r_b + r_s - 32'd8, wdata: r_s};
            end
            S_PUSH0: o_req = '{en: 1'b1, we: 1'b1, addr: r_b, wdata: r_head};
            S_PUSH1: o_req = '{en: 1'b1, we: 1'b1, addr: r_b + 32'd4, wdata: '0};
            S_PUSH2: o_req = '{en: 1'b1, we: 1'b1, addr: r_head + 32'd4, wdata: r_b};
            S_U0: begin
                o_req.en = 1'b1; o_req.addr = r_u;
            end
            S_U1: begin
                o_req.en = 1'b1; o_req.addr = r_u + 32'd4;
            end
            S_U3: o_req = '{en: (r_up != '0), we: 1'b1, addr: r_up, wdata: r_un};
            S_U4: o_req = '{en: (r_un != '0), we: 1'b1, addr: r_un + 32'd4, wdata: r_up};
            S_C0: begin
                o_req.en = 1'b1; o_req.addr = r_b - 32'd4;
            end
            S_C1: begin
                o_req.en = w_split; o_req.addr = r_b;
            end
            S_C2: begin
                o_req.en = 1'b1; o_req.addr = r_b + 32'd4;
            end
            S_CW: begin
                o_req.en = 1'b1;
                o_req.we = 1'b1;
                case (r_cnt)
                    3'd0: o_req.addr = r_b - 32'd4;
                    3'd1: o_req.addr = r_r - 32'd8;
                    3'd2: o_req.addr = r_r - 32'd4;
                    3'd3: o_req.addr = r_r + r_rs - 32'd8;
                    3'd4: o_req.addr = r_r;
                    default: o_req.addr = r_r + 32'd4;
                endcase
                case (r_cnt)
                    3'd0, 3'd1: o_req.wdata = r_asize | 32'd1;
                    3'd2, 3'd3: o_req.wdata = r_rs;
                    3'd4:       o_req.wdata = r_n;
                    default:    o_req.wdata = r_p;
                endcase
            end
            S_C4: o_req = '{en: (r_p != '0), we: 1'b1, addr: r_p, wdata: r_r};
            S_C5: o_req = '{en: (r_n != '0), we: 1'b1, addr: r_n + 32'd4, wdata: r_r};
            S_CN0: o_req = '{en: 1'b1, we: 1'b1, addr: r_b - 32'd4, wdata: r_c | 32'd1};
            S_CN1: o_req = '{en: 1'b1, we: 1'b1, addr: r_b + r_c - 32'd8,
                             wdata: r_c | 32'd1};
            S_F0: begin
                o_req.en = !w_fbad; o_req.addr = t_word'(r_addr) - 32'd4;
            end
            S_FW: begin
                o_req.en = 1'b1;
                o_req.we = 1'b1;
                case (r_cnt[1:0])
                    2'd0: o_req = '{en: 1'b1, we: 1'b1, addr: r_b - 32'd4, wdata: r_s};
                    2'd1: o_req = '{en: 1'b1, we: 1'b1, addr: r_b + r_s - 32'd8,
                                    wdata: r_s};
                    2'd2: o_req = '{en: 1'b1, we: 1'b1, addr: r_b, wdata: '0};
                    default: o_req = '{en: 1'b1, we: 1'b1, addr: r_b + 32'd4, wdata: '0};
                endcase
            end
            default: o_req = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_ov         <= 1'b0;
            r_ready_heap <= 1'b0;
            r_brk        <= '0;
            r_head       <= '0;
            r_count      <= '0;
            r_chunk      <= CHUNK_RESET;
        end else begin
            if (i_cfg.valid) begin
                r_chunk <= i_cfg.chunk_bytes;
            end
            if (w_emit) begin
                r_ov <= 1'b1;
            end else if (o_rsp.ready) begin
                r_ov <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_cmd.valid) begin
                        r_size   <= i_cmd.size_bytes;
                        r_addr   <= i_cmd.block_addr;
                        r_asize  <= (i_cmd.size_bytes <= 16'd8) ? SMALLEST_BLOCK
                                  : ((t_word'(i_cmd.size_bytes) + 32'd15) & SIZE_MASK);
                        r_status <= ST_OK;
                        r_result <= '0;
                        r_cnt    <= '0;
                        if (t_cmd'(i_cmd.command) == CMD_FREE) begin
                            r_state <= S_F0;
                        end else if (!r_ready_heap) begin
                            r_state <= S_LAY;
                        end else begin
                            r_state <= S_ASTART;
                        end
                    end
                end
                // pad, prologue header and footer, epilogue
                S_LAY: begin
                    r_cnt <= r_cnt + 3'd1;
                    if (r_cnt[1:0] == 2'd3) begin
                        r_brk        <= OW'(16);
                        r_ready_heap <= 1'b1;
                        r_gbytes     <= t_word'(r_chunk);
                        r_ret_grow   <= S_ASTART;
                        r_state      <= S_GROW;
                    end
                end
                S_ASTART: begin
                    if (r_size == '0) begin
                        r_status <= ST_NULL;
                        r_state  <= S_DONE;
                    end else begin
                        r_b     <= r_head;
                        r_left  <= r_count;
                        r_state <= S_SRCH;
                    end
                end
                S_SRCH: begin
                    r_state <= ((r_b != '0) && (r_left != '0)) ? S_SRCH_T : S_NOFIT;
                end
                S_SRCH_T: begin
                    if (w_fit) begin
                        r_result <= r_b[15:0];
                        r_state  <= S_C0;
                    end else begin
                        r_state <= S_SRCH_N;
                    end
                end
                S_SRCH_N: begin
                    if ((i_rdata == '0) || (i_rdata > t_word'(r_brk)) || (i_rdata == r_b)) begin
                        r_state <= S_NOFIT;
                    end else begin
                        r_b     <= i_rdata;
                        r_left  <= r_left - t_count'(1);
                        r_state <= S_SRCH;
                    end
                end
                S_NOFIT: begin
                    r_gbytes   <= (r_asize > t_word'(r_chunk)) ? r_asize : t_word'(r_chunk);
                    r_ret_grow <= S_AGROWN;
                    r_state    <= S_GROW;
                end
                S_AGROWN: begin
                    if (r_gfail) begin
                        r_status <= ST_OOM;
                        r_state  <= S_DONE;
                    end else begin
                        r_result <= r_b[15:0];
                        r_state  <= S_C0;
                    end
                end
                S_GROW: begin
                    r_gfail <= w_gfail;
                    if (w_gfail) begin
                        r_state <= r_ret_grow;
                    end else begin
                        r_gn        <= w_gn;
                        r_b         <= t_word'(r_brk);
                        r_brk       <= r_brk + OW'(w_gn);
                        r_cnt       <= '0;
                        r_state     <= S_GROW_W;
                    end
                end
                S_GROW_W: begin
                    r_cnt <= r_cnt + 3'd1;
                    if (r_cnt == 3'd4) begin
                        r_ret_merge <= r_ret_grow;
                        r_state     <= S_M0;
                    end
                end
                // coalesce r_b with free neighbours, then push to list head
                S_M0: r_state <= S_M1;
                S_M1: begin
                    r_s     <= w_tsz;
                    r_state <= S_M2;
                end
                S_M2: begin
                    r_prev_used <= i_rdata[0];
                    r_pr        <= r_b - w_tsz;
                    r_nx        <= r_b + r_s;
                    r_state     <= S_M3;
                end
                S_M3: begin
                    if (!i_rdata[0]) begin
                        r_s       <= r_s + w_tsz;
                        r_u       <= r_nx;
                        r_ret_unl <= S_M4;
                        r_state   <= S_U0;
                    end else begin
                        r_state <= S_M4;
                    end
                end
                S_M4: r_state <= r_prev_used ? S_M6 : S_M5;
                S_M5: begin
                    r_s       <= r_s + w_tsz;
                    r_u       <= r_pr;
                    r_b       <= r_pr;
                    r_ret_unl <= S_M6;
                    r_state   <= S_U0;
                end
                S_M6: r_state <= S_M7;
                S_M7: r_state <= S_PUSH0;
                S_PUSH0: r_state <= S_PUSH1;
                S_PUSH1: begin
                    if (r_head != '0) begin
                        r_state <= S_PUSH2;
                    end else begin
                        r_head  <= r_b;
                        r_count <= r_count + t_count'(1);
                        r_state <= r_ret_merge;
                    end
                end
                S_PUSH2: begin
                    r_head  <= r_b;
                    r_count <= r_count + t_count'(1);
                    r_state <= r_ret_merge;
                end
                // unlink r_u from the free list
                S_U0: r_state <= S_U1;
                S_U1: begin
                    r_un    <= i_rdata;
                    r_state <= S_U2;
                end
                S_U2: begin
                    r_up <= i_rdata;
                    if ((r_u != r_head) && (i_rdata == '0) && (r_un == '0)) begin
                        r_state <= r_ret_unl;
                    end else begin
                        r_state <= S_U3;
                    end
                end
                S_U3: begin
                    if ((r_up == '0) && (r_head == r_u)) begin
                        r_head <= r_un;
                    end
                    r_state <= S_U4;
                end
                S_U4: begin
                    r_count <= r_count - t_count'(1);
                    r_state <= r_ret_unl;
                end
                // mark r_b allocated, split off the remainder where it is big enough
                S_C0: r_state <= S_C1;
                S_C1: begin
                    r_c     <= w_tsz;
                    r_rs    <= w_rem;
                    r_state <= w_split ? S_C2 : S_CN0;
                end
                S_C2: begin
                    r_n     <= i_rdata;
                    r_state <= S_C3;
                end
                S_C3: begin
                    r_p     <= i_rdata;
                    r_r     <= r_b + r_asize;
                    r_cnt   <= '0;
                    r_state <= S_CW;
                end
                S_CW: begin
                    r_cnt <= r_cnt + 3'd1;
                    if (r_cnt == 3'd5) begin
                        r_state <= S_C4;
                    end
                end
                S_C4: begin
                    if ((r_p == '0) && (r_head == r_b)) begin
                        r_head <= r_r;
                    end
                    r_state <= S_C5;
                end
                S_C5: r_state <= S_DONE;
                S_CN0: r_state <= S_CN1;
                S_CN1: begin
                    r_u       <= r_b;
                    r_ret_unl <= S_DONE;
                    r_state   <= S_U0;
                end
                S_F0: begin
                    r_b <= t_word'(r_addr);
                    if (w_fbad) begin
                        r_status <= ST_NULL;
                        r_state  <= S_DONE;
                    end else begin
                        r_state <= S_F1;
                    end
                end
                S_F1: begin
                    if (w_fbad2) begin
                        r_status <= ST_NULL;
                        r_state  <= S_DONE;
                    end else begin
                        r_s     <= w_tsz;
                        r_cnt   <= '0;
                        r_state <= S_FW;
                    end
                end
                S_FW: begin
                    r_cnt <= r_cnt + 3'd1;
                    if (r_cnt[1:0] == 2'd3) begin
                        r_ret_merge <= S_DONE;
                        r_state     <= S_M0;
                    end
                end
                S_DONE: begin
                    if (w_emit) begin
                        r_o_status <= r_status;
                        r_o_result <= r_result;
                        r_o_free   <= r_count;
                        r_state    <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

// ===== hdl/explicit_free_list_allocator.sv =====
// Channel   Dir  Payload                                   Handshake
// i_cmd     in   command, size_bytes, block_addr           valid/ready
// o_rsp     out  status, result_addr, free_blocks          valid/ready
// i_cfg     in   chunk_bytes                               valid/ready (always ready)
//
// One item at a time, one access a cycle to the heap word memory, read data registered in the memory.
// An allocation searches the free list block by block, grows the heap when no block fits
// (the first allocation lays out the heap before that), then marks the block and splits it where big enough.
// A free marks the block free and merges it with free neighbours; an ignored free or a zero size returns NULL.
// Reset is synchronous and clears the control state; the heap memory needs no clearing.
// A waiting result sits in the output register while the next item runs; hold in DONE only
// when the next result is ready before that one is taken.
module explicit_free_list_allocator #(
    parameter int HEAP_BYTES      = efla_pkg::HEAP_BYTES_DEF,
    parameter int MIN_SPLIT_BYTES = efla_pkg::MIN_SPLIT_BYTES_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    efla_cmd_if.sink   i_cmd,
    efla_rsp_if.source o_rsp,
    efla_cfg_if.sink   i_cfg
);
    import efla_pkg::*;

    `include "explicit_free_list_allocator_defines.svh"

    t_mem_req w_req;
    t_word    w_rdata;

    // sequencer: search, carve, grow, coalesce and list upkeep
    efla_ctrl #(
        .HEAP_BYTES      (HEAP_BYTES),
        .MIN_SPLIT_BYTES (MIN_SPLIT_BYTES)
    ) u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (i_cmd),
        .o_rsp   (o_rsp),
        .i_cfg   (i_cfg),
        .o_req   (w_req),
        .i_rdata (w_rdata)
    );

    // heap word memory, one access a cycle
    efla_mem #(
        .HEAP_BYTES (HEAP_BYTES)
    ) u_mem (
        .i_clk   (i_clk),
        .i_req   (w_req),
        .o_rdata (w_rdata)
    );

    // the heap is never touched while waiting for an item
    `EFLA_ASSERT(a_idle_no_mem, i_clk, i_rst_n, i_cmd.ready |-> !w_req.en, "memory access while idle")
    // an allocated block is always 8-byte aligned and only reported with status OK
    `EFLA_ASSERT(a_result_ok, i_clk, i_rst_n, (o_rsp.valid && o_rsp.result_addr != 16'd0) |-> (o_rsp.status == ST_OK && o_rsp.result_addr[2:0] == 3'd0), "bad result address")
    // no status code beyond out of memory
    `EFLA_ASSERT(a_status_code, i_clk, i_rst_n, o_rsp.valid |-> (o_rsp.status != 2'd3), "bad status")
    // while reset is low the block goes idle, ready for an item with no response pending
    `EFLA_ASSERT_ALWAYS(a_reset_idle, i_clk, !i_rst_n |=> (!o_rsp.valid && i_cmd.ready), "not idle after reset")

endmodule
